// File: hdl/moesi_snoop_coherence_macros.svh
// assertion helpers shared by the coherence block
`ifndef MOESI_SNOOP_COHERENCE_MACROS_SVH
`define MOESI_SNOOP_COHERENCE_MACROS_SVH

// plain property, sampled on clk, off while in reset
`define MOESI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication in the same cycle, sampled on clk, off while in reset
`define MOESI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/moesi_pkg.sv
package moesi_pkg;

  // sizes of the shared line state
  localparam int NUM_LINES  = 256;
  localparam int NUM_CACHES = 4;
  localparam int LINE_W     = $clog2(NUM_LINES);
  localparam int CACHE_W    = $clog2(NUM_CACHES);
  localparam int ST_W       = 3;

  // coherence state codes
  localparam logic [ST_W-1:0] ST_I = 3'd0;
  localparam logic [ST_W-1:0] ST_S = 3'd1;
  localparam logic [ST_W-1:0] ST_E = 3'd2;
  localparam logic [ST_W-1:0] ST_O = 3'd3;
  localparam logic [ST_W-1:0] ST_M = 3'd4;

  // access codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // one state per cache for one line
  typedef logic [NUM_CACHES-1:0][ST_W-1:0] line_vec_t;

  // outcome of one access, from the transition logic to the top
  typedef struct packed {
    logic            upd;
    logic            hit;
    logic [ST_W-1:0] old_state;
    logic [ST_W-1:0] new_state;
    logic            peer_held;
  } res_t;

endpackage

// File: hdl/moesi_req_if.sv
interface moesi_req_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [1:0] requester;
  logic [7:0] line_index;

  modport source (output valid, output op, output requester, output line_index,
                  input ready);
  modport sink (input valid, input op, input requester, input line_index,
                output ready);
endinterface

// File: hdl/moesi_rsp_if.sv
interface moesi_rsp_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [2:0] old_state;
  logic [2:0] new_state;
  logic       peer_held;

  modport source (output valid, output hit, output old_state, output new_state,
                  output peer_held, input ready);
  modport sink (input valid, input hit, input old_state, input new_state,
                input peer_held, output ready);
endinterface

// File: hdl/moesi_line_store.sv
module moesi_line_store import moesi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [LINE_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [LINE_W-1:0] wr_addr,
  input  line_vec_t         wr_data,
  output line_vec_t         rd_data
);

  line_vec_t              mem [NUM_LINES];
  logic [NUM_LINES-1:0]   valid;
  line_vec_t              raw_q;
  logic                   vld_q;
  logic                   fwd_q;
  line_vec_t              last_wr;

  // state array, read registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      raw_q <= mem[rd_addr];
    end
  end

  // per-line valid bits, a line never written reads as all invalid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= valid[rd_addr];
        fwd_q <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  // copy of the last write for a read of the same line in the same cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_wr <= wr_data;
    end
  end

  assign rd_data = fwd_q ? last_wr : (vld_q ? raw_q : '0);

endmodule

// File: hdl/moesi_next_state.sv
module moesi_next_state import moesi_pkg::*; (
  input  logic       op,
  input  logic [1:0] requester,
  input  line_vec_t  vec,
  output line_vec_t  vec_next,
  output res_t       res
);

  logic               in_range;
  logic [CACHE_W-1:0] req_idx;
  logic [ST_W-1:0]    old_st;
  logic               rd_peer;
  logic               wr_peer;

  assign in_range = 32'(requester) < NUM_CACHES;
  assign req_idx  = CACHE_W'(requester);

  // requester state, unknown codes taken as invalid
  always_comb begin
    old_st = vec[req_idx];
    if (old_st > ST_M) begin
      old_st = ST_I;
    end
  end

  // snoop all peers in parallel
  always_comb begin
    rd_peer = 1'b0;
    wr_peer = 1'b0;
    for (int c = 0; c < NUM_CACHES; c++) begin
      if (c != int'(requester)) begin
        if (vec[c] == ST_M || vec[c] == ST_O || vec[c] == ST_E || vec[c] == ST_S) begin
          rd_peer = 1'b1;
        end
        if (vec[c] != ST_I) begin
          wr_peer = 1'b1;
        end
      end
    end
  end

  // transitions for requester and peers
  always_comb begin
    vec_next = vec;
    res      = '0;
    if (in_range) begin
      res.upd       = 1'b1;
      res.old_state = old_st;
      if (op == OP_READ) begin
        if (old_st != ST_I) begin
          res.hit       = 1'b1;
          res.new_state = old_st;
        end else begin
          for (int c = 0; c < NUM_CACHES; c++) begin
            if (c != int'(requester)) begin
              if (vec[c] == ST_M || vec[c] == ST_O) begin
                vec_next[c] = ST_O;
              end else if (vec[c] == ST_E) begin
                vec_next[c] = ST_S;
              end
            end
          end
          res.new_state     = rd_peer ? ST_S : ST_E;
          res.peer_held     = rd_peer;
          vec_next[req_idx] = res.new_state;
        end
      end else begin
        res.new_state = ST_M;
        if (old_st == ST_M || old_st == ST_E) begin
          res.hit = 1'b1;
        end else begin
          // upgrade or write miss: every other copy goes away
          for (int c = 0; c < NUM_CACHES; c++) begin
            if (c != int'(requester)) begin
              vec_next[c] = ST_I;
            end
          end
          res.hit       = (old_st != ST_I);
          res.peer_held = (old_st == ST_I) && wr_peer;
        end
        vec_next[req_idx] = ST_M;
      end
    end
  end

endmodule

// File: hdl/moesi_snoop_coherence.sv
// channel   dir  payload                                  handshake
// req       in   op, requester, line_index                valid/ready
// rsp       out  hit, old_state, new_state, peer_held     valid/ready
//
// one request per cycle unless stalled; request register, then result register
// the accepting edge reads the line's state; the transition stage snoops and writes it back
// a write followed by a request to the same line is forwarded, no bubble
// reset clears all line valid bits at once, every line reads as all invalid
// a held result stalls the transition stage and then the request side
module moesi_snoop_coherence import moesi_pkg::*; (
  input logic         clk,
  input logic         rst,
  moesi_req_if.sink   req,
  moesi_rsp_if.source rsp
);

`include "moesi_snoop_coherence_macros.svh"

  logic              accept;
  logic              adv;
  logic              s1_valid;
  logic              s1_op;
  logic [1:0]        s1_req;
  logic [LINE_W-1:0] s1_line;
  line_vec_t         vec;
  line_vec_t         vec_next;
  res_t              res;
  logic              out_valid;
  res_t              out_res;
  logic              rd_done;
  logic              wr_done;
  logic              rd_same;
  logic              rd_shared;

  assign adv       = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || adv;
  assign accept    = req.valid && req.ready;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= req.op;
      s1_req  <= req.requester;
      s1_line <= req.line_index[LINE_W-1:0];
    end
  end

  // line state storage
  moesi_line_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (req.line_index[LINE_W-1:0]),
    .wr_en   (adv && res.upd),
    .wr_addr (s1_line),
    .wr_data (vec_next),
    .rd_data (vec)
  );

  // snoop and state transitions
  moesi_next_state u_next (
    .op        (s1_op),
    .requester (s1_req),
    .vec       (vec),
    .vec_next  (vec_next),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.hit       = out_res.hit;
  assign rsp.old_state = out_res.old_state;
  assign rsp.new_state = out_res.new_state;
  assign rsp.peer_held = out_res.peer_held;

  // terms for the checks below
  assign rd_done   = adv && res.upd && s1_op == OP_READ;
  assign wr_done   = adv && res.upd && s1_op == OP_WRITE;
  assign rd_same   = res.new_state == res.old_state && vec_next == vec;
  assign rd_shared = res.new_state == ST_S;

  // read hits leave the whole line untouched
  `MOESI_ASSERT_IMPL(a_read_hit_quiet, rd_done && res.hit, rd_same, "read hit changed line state")
  // a handled access always leaves the requester with a copy
  `MOESI_ASSERT_IMPL(a_req_valid_after, adv && res.upd, res.new_state != ST_I, "requester left in I")
  // every write ends in modified
  `MOESI_ASSERT_IMPL(a_write_to_m, wr_done, res.new_state == ST_M, "write did not end in M")
  // read miss: shared exactly when a peer answered
  `MOESI_ASSERT_IMPL(a_miss_share, rd_done && !res.hit, res.peer_held == rd_shared, "read miss vs snoop")

endmodule

// File: dv/moesi_snoop_coherence_tb.sv
module moesi_snoop_coherence_tb;
  import moesi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one predicted access outcome, same fields as the result channel
  typedef struct packed {
    logic            hit;
    logic [ST_W-1:0] old_state;
    logic [ST_W-1:0] new_state;
    logic            peer_held;
  } access_outcome_t;

  logic clk;
  logic rst;

  moesi_req_if req_ch ();
  moesi_rsp_if rsp_ch ();

  moesi_snoop_coherence dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // predictor copy of every line's per-cache states
  line_vec_t       line_states [NUM_LINES];
  access_outcome_t pending_outcomes [$];
  int unsigned     mismatches = 0;

  // knobs shared by the test tasks and the ready driver
  bit          src_gaps    = 1'b1;
  bit          sink_steady = 1'b0;
  int unsigned hold_request = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // snoop transition of one access, updates the predicted line states
  function automatic access_outcome_t predict_access(logic op, logic [CACHE_W-1:0] who,
                                                     logic [LINE_W-1:0] line);
    access_outcome_t o;
    line_vec_t       vec;
    logic [ST_W-1:0] prior;
    o = '0;
    vec = line_states[line];
    prior = vec[who];
    o.old_state = prior;
    if (op == OP_READ) begin
      if (prior != ST_I) begin
        o.hit = 1'b1;
        o.new_state = prior;
      end else begin
        // probe peers: owners keep dirty data in O, exclusive drops to shared
        for (int c = 0; c < NUM_CACHES; c++) begin
          if (c != who) begin
            case (vec[c])
              ST_M, ST_O: begin
                vec[c] = ST_O;
                o.peer_held = 1'b1;
              end
              ST_E: begin
                vec[c] = ST_S;
                o.peer_held = 1'b1;
              end
              ST_S: o.peer_held = 1'b1;
              default: ;
            endcase
          end
        end
        o.new_state = o.peer_held ? ST_S : ST_E;
      end
    end else if (prior == ST_M || prior == ST_E) begin
      o.hit = 1'b1;
      o.new_state = ST_M;
    end else if (prior == ST_O || prior == ST_S) begin
      // upgrade: invalidate every other copy
      o.hit = 1'b1;
      for (int c = 0; c < NUM_CACHES; c++)
        if (c != who) vec[c] = ST_I;
      o.new_state = ST_M;
    end else begin
      // write miss: note any peer copy, then invalidate all of them
      for (int c = 0; c < NUM_CACHES; c++) begin
        if (c != who) begin
          if (vec[c] != ST_I) o.peer_held = 1'b1;
          vec[c] = ST_I;
        end
      end
      o.new_state = ST_M;
    end
    vec[who] = o.new_state;
    line_states[line] = vec;
    return o;
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // issue one request, optionally after a one-cycle gap
  task automatic send_request(logic op, logic [CACHE_W-1:0] who, logic [LINE_W-1:0] line);
    access_outcome_t exp_o;
    if (src_gaps && $urandom_range(99) < 7) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.requester  <= who;
    req_ch.line_index <= line;
    do @(posedge clk); while (!req_ch.ready);
    exp_o = predict_access(op, who, line);
    pending_outcomes = {pending_outcomes, exp_o};
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // result ready: random stalls, steady stretches, long hold-offs
  initial begin : rsp_ready_drive
    int unsigned hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (sink_steady) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= 7);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    access_outcome_t exp_o;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (rsp_ch.hit !== exp_o.hit)
          report_mismatch($sformatf("hit got %0b exp %0b", rsp_ch.hit, exp_o.hit));
        if (rsp_ch.old_state !== exp_o.old_state)
          report_mismatch($sformatf("old_state got %0d exp %0d",
                                    rsp_ch.old_state, exp_o.old_state));
        if (rsp_ch.new_state !== exp_o.new_state)
          report_mismatch($sformatf("new_state got %0d exp %0d",
                                    rsp_ch.new_state, exp_o.new_state));
        if (rsp_ch.peer_held !== exp_o.peer_held)
          report_mismatch($sformatf("peer_held got %0b exp %0b",
                                    rsp_ch.peer_held, exp_o.peer_held));
      end
    end
  end

  // walk through most transitions on lines 0, 128 and 255, field extremes included
  task automatic test_directed();
    // line 0: fill, share, upgrade, owner forwarding
    send_request(OP_READ,  2'd0, 8'd0);    // read miss, no peer -> E
    send_request(OP_READ,  2'd0, 8'd0);    // read hit in E
    send_request(OP_WRITE, 2'd0, 8'd0);    // write hit E -> M
    send_request(OP_READ,  2'd1, 8'd0);    // peer M -> O, requester S
    send_request(OP_READ,  2'd2, 8'd0);    // peers O and S
    send_request(OP_READ,  2'd0, 8'd0);    // read hit in O
    send_request(OP_WRITE, 2'd1, 8'd0);    // write hit in S, invalidate all
    send_request(OP_READ,  2'd3, 8'd0);    // peer M -> O
    send_request(OP_WRITE, 2'd1, 8'd0);    // write hit in O, invalidate all
    send_request(OP_WRITE, 2'd1, 8'd0);    // write hit in M
    send_request(OP_WRITE, 2'd0, 8'd0);    // write miss, peer in M
    send_request(OP_WRITE, 2'd2, 8'd0);    // write miss, peer in M again
    // line 255: write miss on an empty line
    send_request(OP_WRITE, 2'd3, 8'd255);
    send_request(OP_READ,  2'd3, 8'd255);  // read hit in M
    send_request(OP_READ,  2'd0, 8'd255);  // peer M -> O
    send_request(OP_WRITE, 2'd0, 8'd255);  // upgrade from S
    // line 128: exclusive downgrade and write miss over sharers
    send_request(OP_READ,  2'd2, 8'd128);
    send_request(OP_READ,  2'd1, 8'd128);  // peer E -> S
    send_request(OP_WRITE, 2'd3, 8'd128);  // write miss over two sharers
    send_request(OP_READ,  2'd3, 8'd128);
    drain_results();
  endtask

  // random accesses, mostly to a few hot lines so states build up
  task automatic test_random(int unsigned count);
    logic [LINE_W-1:0] line;
    for (int unsigned n = 0; n < count; n++) begin
      // no idling on either side for a stretch
      if (n == 400) begin
        src_gaps = 1'b0;
        sink_steady = 1'b1;
      end else if (n == 700) begin
        src_gaps = 1'b1;
        sink_steady = 1'b0;
      end
      // pause now and then until everything is back
      if (n % 250 == 249) drain_results();
      if ($urandom_range(99) < 85) line = LINE_W'($urandom_range(0, 7));
      else line = LINE_W'($urandom_range(0, NUM_LINES - 1));
      send_request(1'($urandom_range(0, 1)), CACHE_W'($urandom_range(0, NUM_CACHES - 1)),
                   line);
    end
    drain_results();
  endtask

  // hold results off long enough that the block backs up into the request side
  task automatic test_backpressure(int unsigned count);
    src_gaps = 1'b0;
    hold_request = 300;
    for (int unsigned n = 0; n < count; n++)
      send_request(1'($urandom_range(0, 1)), CACHE_W'($urandom_range(0, NUM_CACHES - 1)),
                   LINE_W'($urandom_range(0, 3)));
    src_gaps = 1'b1;
    drain_results();
  endtask

  initial begin
    rst                <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.op         <= OP_READ;
    req_ch.requester  <= '0;
    req_ch.line_index <= '0;
    for (int i = 0; i < NUM_LINES; i++) line_states[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(1300);
    test_backpressure(40);

    // let any stray result show up
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
